FILE: rtl/itp_pkg.sv
// Shared types, character codes and precedence functions for the
// infix-to-postfix converter. No dependencies.
`default_nettype none

package itp_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 16;

  // Character codes
  localparam logic [7:0] CH_UPPER_A = 8'd65;
  localparam logic [7:0] CH_UPPER_Z = 8'd90;
  localparam logic [7:0] CH_LOWER_A = 8'd97;
  localparam logic [7:0] CH_LOWER_Z = 8'd122;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SLASH   = 8'h2F;

  localparam logic [7:0] PREC_PAREN_IN = 8'd100;

  // Error codes carried on the end marker
  localparam logic [1:0] ERR_OK        = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
  localparam logic [1:0] ERR_UNMATCHED = 2'd2;

  // Input item kinds
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] symbol;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_symbol;
    logic       is_end;
    logic [1:0] error_code;
  } out_word_t;

  // Shift command handed to every stack cell
  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctrl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EMIT,
    S_OP,
    S_CLOSE,
    S_FLUSH
  } state_e;

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
           ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
           (c == CH_SLASH) || (c == CH_PERCENT) || (c == CH_LPAREN);
  endfunction

  function automatic logic [7:0] prec_incoming(input logic [7:0] c);
    logic [7:0] p;
    if ((c == CH_PLUS) || (c == CH_MINUS)) begin
      p = 8'd1;
    end else if ((c == CH_STAR) || (c == CH_SLASH) || (c == CH_PERCENT)) begin
      p = 8'd3;
    end else begin
      p = PREC_PAREN_IN;
    end
    return p;
  endfunction

  function automatic logic [7:0] prec_stacked(input logic [7:0] c);
    logic [7:0] p;
    if ((c == CH_PLUS) || (c == CH_MINUS)) begin
      p = 8'd2;
    end else if ((c == CH_STAR) || (c == CH_SLASH) || (c == CH_PERCENT)) begin
      p = 8'd4;
    end else begin
      p = 8'd0;
    end
    return p;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/itp_stack_cell.sv
// One entry of the shifting operator stack.
// Depends on itp_pkg for the shift command struct.
`default_nettype none

module itp_stack_cell
  import itp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire stk_ctrl_t  ctrl_i,
  input  wire logic [7:0] above_i,  // neighbor nearer the top (or new symbol)
  input  wire logic [7:0] below_i,  // neighbor deeper in the stack
  output logic [7:0]      sym_o
);

  logic [7:0] sym_q;
  logic [7:0] sym_d;

  // Push: take from above. Pop: take from below. Otherwise hold.
  always_comb begin
    sym_d = sym_q;
    if (ctrl_i.push) begin
      sym_d = above_i;
    end else if (ctrl_i.pop) begin
      sym_d = below_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q <= sym_d;
  end

  assign sym_o = sym_q;

endmodule

`default_nettype wire

FILE: rtl/infix_to_postfix_converter_core.sv
// Top level of the infix-to-postfix converter: control sequencer, output
// register and a chain of itp_stack_cell entries. Depends on itp_pkg.
`default_nettype none

// Shunting-yard converter. Send one character per input word; letters come
// out at once, operators wait on an operator stack built as a chain of cells
// whose top is always cell 0, so every push or pop shifts the whole chain by
// one place. Every output word leaves through a single output register, so
// the sequencer emits at most one word per cycle: a letter is emitted as is,
// an ignored character or an unmatched ')' is dropped without leaving idle,
// an operator first pops and emits each stacked operator of higher rank and
// is then pushed, a ')' pops and emits operators down to the '(' and then
// drops the '(', and an end word pops and emits every stacked entry and then
// the end marker. A push onto a full stack is dropped (error 1); a ')'
// with no '(' stacked is ignored (error 2). The first error of an expression
// rides on the end marker, after which the stack is empty and the error is
// cleared. No clearing pass is needed after reset.
module infix_to_postfix_converter_core
  import itp_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_word_t  in_word_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_word_t      out_word_o
);

  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(STACK_DEPTH);
  localparam logic [CntW-1:0] CntOne = CntW'(1);

  // Control state
  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;        // entries on the stack
  logic [CntW-1:0] open_cnt_q, open_cnt_d;  // '(' entries on the stack
  logic [1:0]      sticky_q, sticky_d;
  logic [7:0]      cur_q, cur_d;        // symbol under work

  // Output register
  logic      out_valid_q;
  out_word_t out_word_q;
  logic      emit;
  out_word_t emit_word;
  logic      out_free;

  // Stack chain
  stk_ctrl_t  ctrl;
  logic [7:0] cell_sym [STACK_DEPTH];
  logic [7:0] top_sym;
  logic       in_accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign top_sym    = cell_sym[0];

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    open_cnt_d = open_cnt_q;
    sticky_d   = sticky_q;
    cur_d      = cur_q;
    ctrl       = '0;
    emit       = 1'b0;
    emit_word  = '{out_symbol: cur_q, is_end: 1'b0, error_code: ERR_OK};

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          cur_d = in_word_i.symbol;
          if (in_word_i.kind == KIND_END) begin
            state_d = S_FLUSH;
          end else if (is_letter(in_word_i.symbol)) begin
            state_d = S_EMIT;
          end else if (is_op(in_word_i.symbol)) begin
            state_d = S_OP;
          end else if (in_word_i.symbol == CH_RPAREN) begin
            // Unmatched close: flag and drop the word
            if (open_cnt_q == '0) begin
              if (sticky_q == ERR_OK) begin
                sticky_d = ERR_UNMATCHED;
              end
            end else begin
              state_d = S_CLOSE;
            end
          end
        end
      end

      S_EMIT: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = S_IDLE;
        end
      end

      S_OP: begin
        if ((cnt_q != '0) && (prec_incoming(cur_q) < prec_stacked(top_sym))) begin
          // Pop a stacked operator of higher rank
          if (out_free) begin
            emit                 = 1'b1;
            emit_word.out_symbol = top_sym;
            ctrl.pop             = 1'b1;
            cnt_d                = cnt_q - CntOne;
            if (top_sym == CH_LPAREN) begin
              open_cnt_d = open_cnt_q - CntOne;
            end
          end
        end else begin
          if (cnt_q < CntMax) begin
            ctrl.push = 1'b1;
            cnt_d     = cnt_q + CntOne;
            if (cur_q == CH_LPAREN) begin
              open_cnt_d = open_cnt_q + CntOne;
            end
          end else if (sticky_q == ERR_OK) begin
            sticky_d = ERR_OVERFLOW;
          end
          state_d = S_IDLE;
        end
      end

      S_CLOSE: begin
        if (top_sym == CH_LPAREN) begin
          // Drop the matching open parenthesis
          ctrl.pop   = 1'b1;
          cnt_d      = cnt_q - CntOne;
          open_cnt_d = open_cnt_q - CntOne;
          state_d    = S_IDLE;
        end else if (out_free) begin
          emit                 = 1'b1;
          emit_word.out_symbol = top_sym;
          ctrl.pop             = 1'b1;
          cnt_d                = cnt_q - CntOne;
        end
      end

      S_FLUSH: begin
        if (out_free) begin
          emit = 1'b1;
          if (cnt_q != '0) begin
            emit_word.out_symbol = top_sym;
            ctrl.pop             = 1'b1;
            cnt_d                = cnt_q - CntOne;
            if (top_sym == CH_LPAREN) begin
              open_cnt_d = open_cnt_q - CntOne;
            end
          end else begin
            emit_word  = '{out_symbol: 8'd0, is_end: 1'b1, error_code: sticky_q};
            sticky_d   = ERR_OK;
            open_cnt_d = '0;
            state_d    = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      open_cnt_q  <= '0;
      sticky_q    <= ERR_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      open_cnt_q <= open_cnt_d;
      sticky_q   <= sticky_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (emit) begin
      out_word_q <= emit_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // Chain of stack cells; cell 0 is the top
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [7:0] above;
    logic [7:0] below;
    if (i == 0) begin : g_top
      assign above = cur_q;
    end else begin : g_mid
      assign above = cell_sym[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign below = cell_sym[i];
    end else begin : g_inner
      assign below = cell_sym[i+1];
    end
    itp_stack_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .above_i (above),
      .below_i (below),
      .sym_o   (cell_sym[i])
    );
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntMax)
    else $error("stack count above depth");

  a_open_le_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_cnt_q <= cnt_q)
    else $error("open parenthesis count above stack count");

  a_close_has_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLOSE) |-> (open_cnt_q != '0))
    else $error("close handling without a stacked open parenthesis");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.pop |-> (cnt_q != '0))
    else $error("pop from an empty stack");
`endif

endmodule

`default_nettype wire

FILE: dv/tb.sv
// Self-checking testbench for infix_to_postfix_converter_core: a queue-fed
// driver, an output monitor and a shunting-yard predictor of its own.
// Depends on rtl/itp_pkg.sv and the RTL of the converter.
`default_nettype none

module tb;
  import itp_pkg::*;

  localparam int OP_DEPTH    = STACK_DEPTH_DEF;
  localparam int LIVE_ITEMS  = 220;   // random stimulus stops near this count
  localparam int HOLD_CYCLES = 300;   // long output hold-off
  localparam int HOLD_AT     = 50;    // words accepted before the hold starts
  localparam int DRAIN_WAIT  = 40;    // settle time after the last result
  localparam int QUIET_LIMIT = 3000;  // cycles with no handshake before giving up

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  infix_to_postfix_converter_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Stimulus and expected postfix words.
  in_word_t  char_q[$];
  out_word_t postfix_q[$];
  int        total_items = 0;
  int        live_count = 0;
  int        words_in = 0;
  int        words_out = 0;
  int        errors = 0;

  // Predictor state: the operator stack, its fill level and the first error.
  logic [7:0] op_stack [OP_DEPTH];
  int         op_depth = 0;
  logic [1:0] open_err = ERR_OK;

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
  endfunction

  function automatic bit is_operator(logic [7:0] c);
    return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH ||
           c == CH_PERCENT || c == CH_LPAREN;
  endfunction

  // Rank of an operator arriving and of one already stacked; '(' arrives
  // with the top rank and sits with the lowest, so nothing pops past it.
  function automatic int incoming_rank(logic [7:0] c);
    if (c == CH_PLUS || c == CH_MINUS) return 1;
    if (c == CH_STAR || c == CH_SLASH || c == CH_PERCENT) return 3;
    return 100;
  endfunction

  function automatic int stacked_rank(logic [7:0] c);
    if (c == CH_PLUS || c == CH_MINUS) return 2;
    if (c == CH_STAR || c == CH_SLASH || c == CH_PERCENT) return 4;
    return 0;
  endfunction

  function automatic void expect_word(logic [7:0] sym, logic last, logic [1:0] err);
    out_word_t w;
    w.out_symbol = sym;
    w.is_end     = last;
    w.error_code = err;
    postfix_q.push_back(w);
  endfunction

  function automatic void pop_to_output();
    op_depth--;
    expect_word(op_stack[op_depth], 1'b0, ERR_OK);
  endfunction

  // Keep only the first error of an expression.
  function automatic void note_error(logic [1:0] err);
    if (open_err == ERR_OK) open_err = err;
  endfunction

  // Advance the predictor by one accepted input word.
  function automatic void predict_postfix(in_word_t w);
    logic [7:0] c;
    bit         found;
    c = w.symbol;
    found = 1'b0;
    if (w.kind == KIND_END) begin
      while (op_depth > 0) pop_to_output();
      expect_word(8'h00, 1'b1, open_err);
      open_err = ERR_OK;
    end else if (is_alpha(c)) begin
      expect_word(c, 1'b0, ERR_OK);
    end else if (is_operator(c)) begin
      while (op_depth > 0 && incoming_rank(c) < stacked_rank(op_stack[op_depth-1]))
        pop_to_output();
      if (op_depth < OP_DEPTH) begin
        op_stack[op_depth] = c;
        op_depth++;
      end else begin
        note_error(ERR_OVERFLOW);
      end
    end else if (c == CH_RPAREN) begin
      for (int i = 0; i < op_depth; i++)
        if (op_stack[i] == CH_LPAREN) found = 1'b1;
      if (!found) begin
        note_error(ERR_UNMATCHED);
      end else begin
        while (op_stack[op_depth-1] != CH_LPAREN) pop_to_output();
        op_depth--;  // drop the '('
      end
    end
  endfunction

  // Queue one input word; ignored characters do not count as live stimulus.
  task automatic add_item(logic kind, logic [7:0] sym);
    in_word_t w;
    w.kind   = kind;
    w.symbol = sym;
    char_q.push_back(w);
    total_items++;
    if (kind == KIND_END || is_alpha(sym) || is_operator(sym) || sym == CH_RPAREN)
      live_count++;
  endtask

  function automatic logic [7:0] pick_letter();
    if ($urandom_range(1) == 0) return CH_UPPER_A + 8'($urandom_range(25));
    return CH_LOWER_A + 8'($urandom_range(25));
  endfunction

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(4))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      3:       return CH_SLASH;
      default: return CH_PERCENT;
    endcase
  endfunction

  // Mostly well-formed expression with random nesting; now and then a stray
  // character, a stray ')' or parentheses left open.
  task automatic gen_expression();
    int operands;
    int depth;
    int n;
    operands = $urandom_range(1, 6);
    depth = 0;
    for (int i = 0; i < operands; i++) begin
      if ($urandom_range(3) == 0) begin
        n = $urandom_range(1, 2);
        repeat (n) add_item(KIND_CHAR, CH_LPAREN);
        depth += n;
      end
      if ($urandom_range(19) == 0) add_item(KIND_CHAR, 8'($urandom_range(255)));
      add_item(KIND_CHAR, pick_letter());
      if (depth > 0 && $urandom_range(2) == 0) begin
        n = $urandom_range(1, depth);
        repeat (n) add_item(KIND_CHAR, CH_RPAREN);
        depth -= n;
      end
      if ($urandom_range(24) == 0) add_item(KIND_CHAR, CH_RPAREN);
      if (i < operands - 1) add_item(KIND_CHAR, pick_operator());
    end
    if ($urandom_range(9) != 0)
      repeat (depth) add_item(KIND_CHAR, CH_RPAREN);
    add_item(KIND_END, 8'($urandom_range(255)));
  endtask

  // Deep nesting that may run past the stack and overflow it.
  task automatic gen_deep();
    int groups;
    groups = $urandom_range(10, 19);
    repeat (groups) begin
      add_item(KIND_CHAR, CH_LPAREN);
      if ($urandom_range(1) == 0) begin
        add_item(KIND_CHAR, pick_letter());
        add_item(KIND_CHAR, pick_operator());
      end
    end
    add_item(KIND_CHAR, pick_letter());
    if ($urandom_range(1) == 0) add_item(KIND_CHAR, CH_RPAREN);
    add_item(KIND_END, 8'($urandom_range(255)));
  endtask

  // Sender idles 10 %, then 54 %, then never; the receiver the other way round.
  function automatic int send_idle_pct();
    if (words_in < total_items / 3) return 10;
    if (words_in < 2 * total_items / 3) return 54;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (words_in < total_items / 3) return 54;
    if (words_in < 2 * total_items / 3) return 10;
    return 0;
  endfunction

  // Driver: hold a stalled word, advance to the next one once it is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_postfix(in_word);
        words_in <= words_in + 1;
      end
      if (!in_valid || !in_stall) begin
        if (char_q.size() > 0 && $urandom_range(99) >= send_idle_pct()) begin
          in_word  <= char_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver: check each output word, stall at random, and once
  // hold off for a long stretch so the stack and the input back up.
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        words_out <= words_out + 1;
        if (postfix_q.size() == 0) begin
          $display("%0t: unexpected word sym %h end %b err %0d", $time,
                   out_word.out_symbol, out_word.is_end, out_word.error_code);
          errors++;
        end else begin
          want = postfix_q.pop_front();
          if (out_word.out_symbol !== want.out_symbol || out_word.is_end !== want.is_end ||
              out_word.error_code !== want.error_code) begin
            $display("%0t: expected sym %h end %b err %0d, got sym %h end %b err %0d",
                     $time, want.out_symbol, want.is_end, want.error_code,
                     out_word.out_symbol, out_word.is_end, out_word.error_code);
            errors++;
          end
        end
      end
      if (!hold_done && words_in == HOLD_AT) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct());
      end
    end
  end

  // Watchdog: give up after too long without any handshake.
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    // Directed: a mixed expression with nesting and every operator.
    add_item(KIND_CHAR, CH_UPPER_A);
    add_item(KIND_CHAR, CH_PLUS);
    add_item(KIND_CHAR, CH_LOWER_Z);
    add_item(KIND_CHAR, CH_STAR);
    add_item(KIND_CHAR, CH_LPAREN);
    add_item(KIND_CHAR, CH_UPPER_Z);
    add_item(KIND_CHAR, CH_MINUS);
    add_item(KIND_CHAR, CH_LOWER_A);
    add_item(KIND_CHAR, CH_RPAREN);
    add_item(KIND_CHAR, CH_SLASH);
    add_item(KIND_CHAR, pick_letter());
    add_item(KIND_CHAR, CH_PERCENT);
    add_item(KIND_CHAR, pick_letter());
    add_item(KIND_END, 8'h00);
    // Unmatched close, ignored characters at both ends of the byte range and just
    // outside the letter ranges, a '(' left open, then an end word with every symbol bit set.
    add_item(KIND_CHAR, CH_RPAREN);
    add_item(KIND_CHAR, 8'h00);
    add_item(KIND_CHAR, 8'hFF);
    add_item(KIND_CHAR, CH_UPPER_A - 8'd1);
    add_item(KIND_CHAR, CH_UPPER_Z + 8'd1);
    add_item(KIND_CHAR, CH_LOWER_A - 8'd1);
    add_item(KIND_CHAR, CH_LOWER_Z + 8'd1);
    add_item(KIND_CHAR, CH_LPAREN);
    add_item(KIND_CHAR, pick_letter());
    add_item(KIND_END, 8'hFF);

    while (live_count < LIVE_ITEMS) begin
      if ($urandom_range(7) == 0) gen_deep();
      else gen_expression();
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every word to go in and every expected word to come out.
    while (char_q.size() > 0 || in_valid || postfix_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (errors == 0 && postfix_q.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
